// ===== hdl/lra_pkg.sv =====
// shared types, constants and helpers for the label region adjacency block
// no dependencies; imported by every module of the block
package lra_pkg;

	localparam int LABEL_W    = 8;
	localparam int MAX_LABELS = 256;
	localparam int MAX_WIDTH  = 1024;
	localparam int CFG_W      = 11;
	localparam int IDX_W      = $clog2(MAX_LABELS);
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int EFF_W      = $clog2(MAX_WIDTH + 1);
	localparam int PAIR_W     = 2 * IDX_W;
	localparam int MAT_DEPTH  = 2 ** PAIR_W;
	localparam int OPQ_DEPTH  = 4;
	localparam int OUT_DEPTH  = 2;

	localparam logic [CFG_W-1:0] WIDTH_RESET = CFG_W'(1024);

	localparam logic [1:0] CMD_PIXEL = 2'd0;
	localparam logic [1:0] CMD_QUERY = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	typedef enum logic [1:0] {
		OP_EDGE,
		OP_QUERY,
		OP_CLEAR
	} op_kind_t;

	typedef struct packed {
		op_kind_t               kind;
		logic                   left_en;
		logic                   up_en;
		logic [LABEL_W-1:0]     lab;
		logic [LABEL_W-1:0]     left_lab;
		logic [LABEL_W-1:0]     up_lab;
		logic [LABEL_W-1:0]     other_lab;
	} op_t;

	function automatic logic label_ok(input logic [LABEL_W-1:0] a);
		return {1'b0, a} < (LABEL_W + 1)'(MAX_LABELS);
	endfunction

	// one address per unordered pair in each bank, lower label first
	function automatic logic [PAIR_W-1:0] pair_addr(input logic [LABEL_W-1:0] a,
		input logic [LABEL_W-1:0] b);
		logic [IDX_W-1:0] lo;
		logic [IDX_W-1:0] hi;
		if (a < b) begin
			lo = a[IDX_W-1:0];
			hi = b[IDX_W-1:0];
		end else begin
			lo = b[IDX_W-1:0];
			hi = a[IDX_W-1:0];
		end
		return {lo, hi};
	endfunction

endpackage

// ===== hdl/label_region_adjacency.sv =====
// label region adjacency top level: front end, op queue, back end
// throughput one word per cycle while full is low; queries are taken while the result queue has room
// a query result passes the front stage, the op queue, the matrix read and the result queue
// a clear word starts a sweep of every matrix entry, one entry a cycle; later words wait in the op queue
// and full rises once it fills; after reset full stays high until the first sweep ends; width resets to 1024
// depends on lra_pkg, lra_front, lra_opq, lra_back
module label_region_adjacency import lra_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [1:0]         cmd,
	input  logic [LABEL_W-1:0] label,
	input  logic [LABEL_W-1:0] other_label,
	output logic               empty,
	input  logic               pop,
	output logic               adjacent,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [CFG_W-1:0]   cfg_data
);

	logic init_busy;
	logic f_valid;
	logic f_ready;
	op_t  f_op;
	logic b_valid;
	logic b_ready;
	op_t  b_op;

	assign cfg_ready = 1'b1;

	lra_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.cmd         (cmd),
		.label       (label),
		.other_label (other_label),
		.cfg_valid   (cfg_valid),
		.cfg_data    (cfg_data),
		.init_busy   (init_busy),
		.op_valid    (f_valid),
		.op_ready    (f_ready),
		.op          (f_op)
	);

	lra_opq u_opq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.in_op     (f_op),
		.out_valid (b_valid),
		.out_ready (b_ready),
		.out_op    (b_op)
	);

	lra_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_valid  (b_valid),
		.op_ready  (b_ready),
		.op        (b_op),
		.init_busy (init_busy),
		.empty     (empty),
		.pop       (pop),
		.adjacent  (adjacent)
	);

endmodule

// ===== hdl/lra_front.sv =====
// front end: accepts words, tracks raster position, holds the line store
// and the width register; pixel, query, clear words become back end ops
// depends on lra_pkg
module lra_front import lra_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [1:0]         cmd,
	input  logic [LABEL_W-1:0] label,
	input  logic [LABEL_W-1:0] other_label,
	input  logic               cfg_valid,
	input  logic [CFG_W-1:0]   cfg_data,
	input  logic               init_busy,
	output logic               op_valid,
	input  logic               op_ready,
	output op_t                op
);

	logic [CFG_W-1:0]   width_q;
	logic [COL_W-1:0]   col_q;
	logic [LABEL_W-1:0] left_q;
	logic               first_q;
	logic [LABEL_W-1:0] line_q [MAX_WIDTH];

	logic               s1_v;
	op_kind_t           kind_s1;
	logic [LABEL_W-1:0] lab_s1;
	logic [LABEL_W-1:0] left_s1;
	logic [LABEL_W-1:0] other_s1;
	logic               left_en_s1;
	logic               up_en_s1;
	logic [LABEL_W-1:0] upper_s1;

	logic [EFF_W-1:0]   eff_w;
	logic               wrap_in;
	logic [COL_W-1:0]   col_cur;
	logic               first_cur;
	logic [EFF_W-1:0]   col_inc;
	logic               wrap_out;
	logic               acc;
	logic               load;
	logic               is_pix;
	logic               is_clr;
	op_kind_t           kind_d;

	always_comb begin
		if (width_q == '0)
			eff_w = EFF_W'(1);
		else if (32'(width_q) > MAX_WIDTH)
			eff_w = EFF_W'(MAX_WIDTH);
		else
			eff_w = EFF_W'(width_q);
	end

	assign wrap_in   = EFF_W'(col_q) >= eff_w;
	assign col_cur   = wrap_in ? '0 : col_q;
	assign first_cur = wrap_in ? 1'b0 : first_q;
	assign col_inc   = EFF_W'(col_cur) + EFF_W'(1);
	assign wrap_out  = col_inc >= eff_w;

	assign full = init_busy || (s1_v && !op_ready);
	assign acc  = push && !full;

	always_comb begin
		load   = 1'b0;
		is_pix = 1'b0;
		is_clr = 1'b0;
		kind_d = OP_EDGE;
		unique case (cmd)
			CMD_PIXEL: begin
				load   = acc;
				is_pix = acc;
			end
			CMD_QUERY: begin
				load   = acc;
				kind_d = OP_QUERY;
			end
			CMD_CLEAR: begin
				load   = acc;
				is_clr = acc;
				kind_d = OP_CLEAR;
			end
			default: begin
				load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= WIDTH_RESET;
			col_q   <= '0;
			left_q  <= '0;
			first_q <= 1'b1;
			s1_v    <= 1'b0;
		end else begin
			if (cfg_valid)
				width_q <= cfg_data;
			if (is_pix) begin
				col_q   <= wrap_out ? '0 : col_inc[COL_W-1:0];
				first_q <= wrap_out ? 1'b0 : first_cur;
				left_q  <= label;
			end else if (is_clr) begin
				col_q   <= '0;
				left_q  <= '0;
				first_q <= 1'b1;
			end
			if (load)
				s1_v <= 1'b1;
			else if (op_ready)
				s1_v <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_s1    <= kind_d;
			lab_s1     <= label;
			left_s1    <= left_q;
			other_s1   <= other_label;
			left_en_s1 <= (col_cur != '0) && (left_q != label) && label_ok(label)
				&& label_ok(left_q);
			up_en_s1   <= !first_cur;
		end
		if (is_pix) begin
			upper_s1        <= line_q[col_cur];
			line_q[col_cur] <= label;
		end
	end

	assign op_valid     = s1_v;
	assign op.kind      = kind_s1;
	assign op.left_en   = left_en_s1;
	assign op.up_en     = up_en_s1 && (upper_s1 != lab_s1) && label_ok(upper_s1)
		&& label_ok(lab_s1);
	assign op.lab       = lab_s1;
	assign op.left_lab  = left_s1;
	assign op.up_lab    = upper_s1;
	assign op.other_lab = other_s1;

endmodule

// ===== hdl/lra_opq.sv =====
// short op queue between front end and back end
// depends on lra_pkg for the op type and depth
module lra_opq import lra_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  op_t  in_op,
	output logic out_valid,
	input  logic out_ready,
	output op_t  out_op
);

	localparam int AW = $clog2(OPQ_DEPTH);
	localparam int CW = $clog2(OPQ_DEPTH + 1);

	op_t            mem_q [OPQ_DEPTH];
	logic [AW-1:0]  wptr_q;
	logic [AW-1:0]  rptr_q;
	logic [CW-1:0]  cnt_q;
	logic           wr;
	logic           rd;

	assign in_ready  = cnt_q != CW'(OPQ_DEPTH);
	assign out_valid = cnt_q != '0;
	assign out_op    = mem_q[rptr_q];
	assign wr        = in_valid && in_ready;
	assign rd        = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (wr)
				wptr_q <= wptr_q + 1'b1;
			if (rd)
				rptr_q <= rptr_q + 1'b1;
			cnt_q <= cnt_q + CW'(wr) - CW'(rd);
		end
	end

	always_ff @(posedge clk) begin
		if (wr)
			mem_q[wptr_q] <= in_op;
	end

endmodule

// ===== hdl/lra_back.sv =====
// back end: adjacency matrix in two bit banks, clear sweep, query reads
// and the result queue
// depends on lra_pkg
module lra_back import lra_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic op_valid,
	output logic op_ready,
	input  op_t  op,
	output logic init_busy,
	output logic empty,
	input  logic pop,
	output logic adjacent
);

	typedef enum logic {
		ST_RUN,
		ST_CLEAR
	} state_t;

	localparam int OUT_AW = $clog2(OUT_DEPTH);
	localparam int OUT_CW = $clog2(OUT_DEPTH + 1);

	state_t             state_q;
	logic [PAIR_W-1:0]  sweep_q;
	logic               init_q;
	logic               rd_v_q;

	logic               bank0_q [MAT_DEPTH];
	logic               bank1_q [MAT_DEPTH];
	logic               rd0_q;
	logic               rd1_q;
	logic               qok_q;

	logic               out_q [OUT_DEPTH];
	logic [OUT_AW-1:0]  owptr_q;
	logic [OUT_AW-1:0]  orptr_q;
	logic [OUT_CW-1:0]  ocnt_q;

	logic               room;
	logic               take;
	logic               we0;
	logic               we1;
	logic               re;
	logic               clr_we;
	logic               opop;
	logic [PAIR_W-1:0]  a0;
	logic [PAIR_W-1:0]  a1;
	logic [PAIR_W-1:0]  qa;

	assign room     = (32'(ocnt_q) + 32'(rd_v_q)) < OUT_DEPTH;
	assign take     = (state_q == ST_RUN) && op_valid && ((op.kind != OP_QUERY) || room);
	assign op_ready = take;
	assign we0      = take && (op.kind == OP_EDGE) && op.left_en;
	assign we1      = take && (op.kind == OP_EDGE) && op.up_en;
	assign re       = take && (op.kind == OP_QUERY);
	assign clr_we   = state_q == ST_CLEAR;
	assign a0       = pair_addr(op.lab, op.left_lab);
	assign a1       = pair_addr(op.lab, op.up_lab);
	assign qa       = pair_addr(op.lab, op.other_lab);
	assign init_busy = init_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			sweep_q <= '0;
			init_q  <= 1'b1;
			rd_v_q  <= 1'b0;
		end else begin
			rd_v_q <= re;
			unique case (state_q)
				ST_RUN: begin
					if (take && (op.kind == OP_CLEAR)) begin
						state_q <= ST_CLEAR;
						sweep_q <= '0;
					end
				end
				ST_CLEAR: begin
					sweep_q <= sweep_q + 1'b1;
					if (sweep_q == PAIR_W'(MAT_DEPTH - 1)) begin
						state_q <= ST_RUN;
						init_q  <= 1'b0;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (clr_we) begin
			bank0_q[sweep_q] <= 1'b0;
			bank1_q[sweep_q] <= 1'b0;
		end else begin
			if (we0)
				bank0_q[a0] <= 1'b1;
			if (we1)
				bank1_q[a1] <= 1'b1;
		end
		if (re) begin
			rd0_q <= bank0_q[qa];
			rd1_q <= bank1_q[qa];
			qok_q <= label_ok(op.lab) && label_ok(op.other_lab);
		end
	end

	// result queue
	assign empty    = ocnt_q == '0;
	assign adjacent = out_q[orptr_q];
	assign opop     = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owptr_q <= '0;
			orptr_q <= '0;
			ocnt_q  <= '0;
		end else begin
			if (rd_v_q)
				owptr_q <= owptr_q + 1'b1;
			if (opop)
				orptr_q <= orptr_q + 1'b1;
			ocnt_q <= ocnt_q + OUT_CW'(rd_v_q) - OUT_CW'(opop);
		end
	end

	always_ff @(posedge clk) begin
		if (rd_v_q)
			out_q[owptr_q] <= (rd0_q | rd1_q) & qok_q;
	end

endmodule

// ===== hdl/lra_checker.sv =====
// port-level checks for label_region_adjacency, bound to the top level
// depends on lra_pkg and label_region_adjacency
module lra_checker import lra_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               push,
	input logic               full,
	input logic [1:0]         cmd,
	input logic [LABEL_W-1:0] label,
	input logic [LABEL_W-1:0] other_label,
	input logic               empty,
	input logic               pop,
	input logic               adjacent
);

	logic [7:0] pend_q;
	logic       same_q;
	logic       q_acc;
	logic       r_acc;

	assign q_acc = push && !full && (cmd == CMD_QUERY);
	assign r_acc = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			same_q <= 1'b0;
		end else begin
			pend_q <= pend_q + 8'(q_acc) - 8'(r_acc);
			if (q_acc)
				same_q <= label == other_label;
		end
	end

	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> full && empty)
		else $error("ports not quiet in reset");

	a_no_stray_word: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> pend_q != '0)
		else $error("result word without a pending query");

	a_self_pair: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (pend_q == 8'd1) && same_q) |-> !adjacent)
		else $error("label reported adjacent to itself");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(adjacent)))
		else $error("waiting result word changed");

endmodule

bind label_region_adjacency lra_checker u_lra_checker (.*);
